[design/tscns_pkg.sv]
// ----------------------------------------------------------------------------
// tscns_pkg
// Shared types and constants for the cycle counter to nanoseconds converter.
// ----------------------------------------------------------------------------
package tscns_pkg;

	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_REF_TIMESTAMP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_SYSTEM_NS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FRACTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_STABLE = 3'd4;

	typedef struct packed {
		logic [63:0]       ref_timestamp;
		logic [63:0]       ref_system_ns;
		logic [31:0]       scale_fraction;
		logic signed [6:0] scale_shift;
		logic              counter_stable;
	} cfg_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic        valid;
		logic [63:0] data;
	} q_head_t;

endpackage

[design/tscns_cfg.sv]
// ----------------------------------------------------------------------------
// tscns_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tscns_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [tscns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	output tscns_pkg::cfg_t                cfg
);

	tscns_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tscns_pkg::CFG_REF_TIMESTAMP:  cfg_q.ref_timestamp  <= cfg_data;
				tscns_pkg::CFG_REF_SYSTEM_NS:  cfg_q.ref_system_ns  <= cfg_data;
				tscns_pkg::CFG_SCALE_FRACTION: cfg_q.scale_fraction <= cfg_data[31:0];
				tscns_pkg::CFG_SCALE_SHIFT:    cfg_q.scale_shift    <= signed'(cfg_data[6:0]);
				tscns_pkg::CFG_COUNTER_STABLE: cfg_q.counter_stable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/tscns_front.sv]
// ----------------------------------------------------------------------------
// tscns_front
// Accepts readings, subtracts and shifts, scales by the fraction, adds the
// reference time and pushes the unheld result into the queue.
// ----------------------------------------------------------------------------
module tscns_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tscns_pkg::cfg_t             cfg,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,
	input  logic [tscns_pkg::QCNT_W-1:0] q_count,
	output logic                        push,
	output logic [63:0]                 push_data
);

	logic        valid_s1, valid_s2;
	logic [63:0] shifted_s1;
	logic [63:0] lo_prod_s2, hi_prod_s2;
	logic [63:0] delta;
	logic [63:0] shifted;
	logic [6:0]  amount;
	logic [tscns_pkg::QCNT_W-1:0] used;
	logic        accept;

	// room is reserved for every beat still in the pipeline
	assign used     = q_count + tscns_pkg::QCNT_W'(valid_s1) + tscns_pkg::QCNT_W'(valid_s2);
	assign s_tready = (used < tscns_pkg::QCNT_W'(tscns_pkg::QDEPTH));
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		delta  = (s_tdata > cfg.ref_timestamp) ? (s_tdata - cfg.ref_timestamp) : 64'd0;
		amount = cfg.scale_shift[6] ? (~cfg.scale_shift + 7'd1) : cfg.scale_shift;
		// amount of 64 on a right shift clears the word
		shifted = cfg.scale_shift[6] ? (delta >> amount) : (delta << amount);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		shifted_s1 <= shifted;
		lo_prod_s2 <= 64'(cfg.scale_fraction) * 64'(shifted_s1[31:0]);
		hi_prod_s2 <= 64'(cfg.scale_fraction) * 64'(shifted_s1[63:32]);
	end

	assign push      = valid_s2;
	assign push_data = (lo_prod_s2 >> 32) + hi_prod_s2 + cfg.ref_system_ns;

endmodule

[design/tscns_queue.sv]
// ----------------------------------------------------------------------------
// tscns_queue
// Small FIFO between the conversion pipeline and the monotonic hold.
// ----------------------------------------------------------------------------
module tscns_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [63:0]                  push_data,
	input  logic                         pop,
	output tscns_pkg::q_head_t           head,
	output logic [tscns_pkg::QCNT_W-1:0] count
);

	logic [63:0]                  mem [tscns_pkg::QDEPTH];
	logic [tscns_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tscns_pkg::QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + tscns_pkg::QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + tscns_pkg::QPTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + tscns_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - tscns_pkg::QCNT_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	assign head.valid = (count_q != '0);
	assign head.data  = mem[rd_ptr_q];
	assign count      = count_q;

endmodule

[design/tscns_back.sv]
// ----------------------------------------------------------------------------
// tscns_back
// Monotonic hold against the greatest value returned, and the output register.
// ----------------------------------------------------------------------------
module tscns_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               counter_stable,
	input  tscns_pkg::q_head_t head,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata
);

	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [63:0] last_time_q;
	logic        below;

	assign pop   = head.valid && (!out_valid_q || m_tready);
	assign below = (head.data < last_time_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_time_q <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && !counter_stable && !below) last_time_q <= head.data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_data_q <= (!counter_stable && below) ? last_time_q : head.data;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[design/tsc_to_ns_monotonic_clock_top.sv]
// ----------------------------------------------------------------------------
// tsc_to_ns_monotonic_clock_top
// Cycle counter reading to nanoseconds, with optional monotonic hold.
//
// channel   dir  signals                          payload
// s_*       in   s_tvalid s_tready s_tdata[63:0]  cycle_count
// m_*       out  m_tvalid m_tready m_tdata[63:0]  time_ns
// cfg_*     in   cfg_wen cfg_index[2:0] cfg_data  register write, no handshake
//
// one beat per cycle while m_tready stays high; a beat is registered after the
// subtract/shift, then as two 32x32 products, then added into the queue, then
// in the hold register
// s_tready drops once the eight queue entries are all claimed by stored beats
// and beats still in the two pipeline stages; the queue lets the front run on
// while m_tready is low
// arst_n clears valid flags, queue pointers, held maximum and config registers
// ----------------------------------------------------------------------------
module tsc_to_ns_monotonic_clock_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [63:0]                    s_tdata,   // [63:0] cycle_count
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [63:0]                    m_tdata,   // [63:0] time_ns
	input  logic                           cfg_wen,
	input  logic [tscns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);

	tscns_pkg::cfg_t              cfg;
	tscns_pkg::q_head_t           head;
	logic [tscns_pkg::QCNT_W-1:0] q_count;
	logic                         push, pop;
	logic [63:0]                  push_data;

	tscns_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tscns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	tscns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.count     (q_count)
	);

	tscns_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.counter_stable (cfg.counter_stable),
		.head           (head),
		.pop            (pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

endmodule

[tb/tsc_to_ns_monotonic_clock_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_to_ns_monotonic_clock_top_test
// Streams cycle counter readings through the converter and checks every
// time_ns beat against a local predictor of the offset, shift, fractional
// scale, wrap and monotonic hold, over directed corners and random sweeps.
// ----------------------------------------------------------------------------
module tsc_to_ns_monotonic_clock_top_test;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [63:0]                     s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b1;
	logic [63:0]                     m_tdata;
	logic                            cfg_wen = 1'b0;
	logic [tscns_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]                     cfg_data = '0;

	// predictor copy of the registers and the held maximum
	logic [63:0]       base_count = '0;
	logic [63:0]       base_ns = '0;
	logic [31:0]       frac = '0;
	logic signed [6:0] pre_shift = '0;
	logic              stable = 1'b0;
	logic [63:0]       peak_ns = '0;

	logic [63:0] expected_ns[$];
	int          errors = 0;
	int          readings_sent = 0;
	int          beats_checked = 0;
	int          settings_used = 0;
	bit          no_gaps = 1'b0;
	bit          no_stalls = 1'b0;
	int          stall_left = 0;

	tsc_to_ns_monotonic_clock_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] predict_time_ns(input logic [63:0] reading);
		logic [63:0] delta;
		logic [63:0] shifted;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] t;
		int          sh;
		int          amt;
		delta = (reading > base_count) ? reading - base_count : 64'd0;
		sh = pre_shift;
		amt = (sh < 0) ? -sh : sh;
		if (amt >= 64) begin
			shifted = '0;
		end else if (sh < 0) begin
			shifted = delta >> amt;
		end else begin
			shifted = delta << amt;
		end
		lo = ({32'd0, frac} * {32'd0, shifted[31:0]}) >> 32;
		hi = {32'd0, frac} * {32'd0, shifted[63:32]};
		t = lo + hi + base_ns;
		if (!stable) begin
			if (t < peak_ns) begin
				t = peak_ns;
			end else begin
				peak_ns = t;
			end
		end
		return t;
	endfunction

	// each accepted reading queues its predicted time
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_ns.push_back(predict_time_ns(s_tdata));
		end
	end

	// result side: random stalls after each beat, then compare
	always @(posedge clk) begin : rx_check
		logic [63:0] want;
		if (m_tvalid && m_tready) begin
			if (expected_ns.size() == 0) begin
				$display("%0t: unexpected time_ns beat, expected none, actual %h",
					$time, m_tdata);
				errors++;
			end else begin
				want = expected_ns.pop_front();
				beats_checked++;
				if (m_tdata !== want) begin
					$display("%0t: time_ns mismatch, expected %h, actual %h",
						$time, want, m_tdata);
					errors++;
				end
			end
			stall_left = no_stalls ? 0 : $urandom_range(0, 3);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		m_tready <= (stall_left == 0);
	end

	task automatic send_reading(input logic [63:0] reading);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= reading;
		do @(posedge clk); while (!s_tready);
		readings_sent++;
	endtask

	// stop sending, let every queued result arrive, then cover the pipeline
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_ns.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tscns_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] data);
		wait_idle();
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			tscns_pkg::CFG_REF_TIMESTAMP:  base_count = data;
			tscns_pkg::CFG_REF_SYSTEM_NS:  base_ns = data;
			tscns_pkg::CFG_SCALE_FRACTION: frac = data[31:0];
			tscns_pkg::CFG_SCALE_SHIFT:    pre_shift = data[6:0];
			tscns_pkg::CFG_COUNTER_STABLE: stable = data[0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [63:0] ts, input logic [63:0] ns,
			input logic [31:0] fr, input logic [6:0] sh, input logic st);
		write_reg(tscns_pkg::CFG_REF_TIMESTAMP, ts);
		write_reg(tscns_pkg::CFG_REF_SYSTEM_NS, ns);
		write_reg(tscns_pkg::CFG_SCALE_FRACTION, {$urandom(), fr});
		write_reg(tscns_pkg::CFG_SCALE_SHIFT, {57'(rand64()), sh});
		write_reg(tscns_pkg::CFG_COUNTER_STABLE, {63'(rand64()), st});
		settings_used++;
	endtask

	// all registers still at reset: zero scale, so every answer is zero
	task automatic test_reset_values();
		send_reading(64'd0);
		send_reading(64'hFFFF_FFFF_FFFF_FFFF);
		send_reading(rand64());
	endtask

	// readings before, at and after the reference, then a step back under hold
	task automatic test_reference_clamp();
		set_all(64'h0000_0001_0000_0000, 64'd5000, 32'h8000_0000, 7'd0, 1'b0);
		send_reading(64'h0000_0000_FFFF_FFFF);
		send_reading(64'h0000_0001_0000_0000);
		send_reading(64'h0000_0001_0000_07D0);
		send_reading(64'h0000_0001_0000_03E8);
		send_reading(64'hFFFF_FFFF_FFFF_FFFF);
		send_reading(64'h0000_0001_0000_0010);
	endtask

	task automatic test_shift_extremes();
		set_all(64'd3, 64'd0, 32'hFFFF_FFFF, 7'sd63, 1'b1);
		send_reading(64'd6);
		send_reading(64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(tscns_pkg::CFG_SCALE_SHIFT, 64'h41);
		send_reading(64'hFFFF_FFFF_FFFF_FFFF);
		// most negative shift empties the delta
		write_reg(tscns_pkg::CFG_SCALE_SHIFT, 64'h40);
		send_reading(64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// large products and the base time both wrap at 64 bits
	task automatic test_sum_wrap();
		set_all(64'd0, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 7'd0, 1'b1);
		send_reading(64'h1000);
		send_reading(64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(tscns_pkg::CFG_COUNTER_STABLE, 64'd0);
		send_reading(64'h10);
		send_reading(64'h1000);
		send_reading(64'h20);
	endtask

	// writes outside the register map and excess data bits change nothing
	task automatic test_ignored_writes();
		set_all(64'd100, 64'd0, 32'h1000_0000, 7'sd2, 1'b0);
		for (int i = tscns_pkg::CFG_COUNTER_STABLE + 1; i < (1 << tscns_pkg::CFG_IDX_W);
				i++) begin
			write_reg(i[tscns_pkg::CFG_IDX_W-1:0], rand64());
		end
		write_reg(tscns_pkg::CFG_SCALE_FRACTION, 64'hFFFF_FFFF_2000_0000);
		write_reg(tscns_pkg::CFG_COUNTER_STABLE, 64'hFFFF_FFFF_FFFF_FFFE);
		send_reading(64'd1100);
		send_reading(64'd900);
		send_reading(64'd2100);
	endtask

	// one random register setting, then mostly rising readings with some noise
	task automatic test_random_phase(input int n_items);
		logic [63:0] ts;
		logic [63:0] ns;
		logic [31:0] fr;
		logic [6:0]  sh;
		logic [63:0] cursor;
		logic [63:0] reading;
		case ($urandom_range(0, 3))
			0:       ts = 64'd0;
			1:       ts = 64'hFFFF_FFFF_FFFF_FF00;
			2:       ts = {32'd0, $urandom()};
			default: ts = rand64();
		endcase
		case ($urandom_range(0, 3))
			0:       ns = 64'd0;
			1:       ns = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 1 << 20);
			default: ns = rand64();
		endcase
		case ($urandom_range(0, 3))
			0:       fr = 32'd0;
			1:       fr = 32'hFFFF_FFFF;
			default: fr = $urandom();
		endcase
		case ($urandom_range(0, 5))
			0:       sh = 7'h40;
			1:       sh = 7'sd63;
			2:       sh = 7'($urandom());
			default: sh = 7'($urandom_range(0, 16) - 8);
		endcase
		set_all(ts, ns, fr, sh, 1'($urandom_range(0, 1)));
		no_gaps = ($urandom_range(0, 2) == 0);
		no_stalls = ($urandom_range(0, 2) == 0);
		cursor = ts - $urandom_range(0, 16);
		repeat (n_items) begin
			case ($urandom_range(0, 19))
				0, 1: reading = rand64();
				2:    reading = cursor - $urandom_range(1, 1 << 16);
				default: begin
					cursor += $urandom_range(0, 1 << $urandom_range(0, 24));
					reading = cursor;
				end
			endcase
			send_reading(reading);
		end
		no_gaps = 1'b0;
		no_stalls = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_reference_clamp();
		test_shift_extremes();
		test_sum_wrap();
		test_ignored_writes();
		repeat (6) test_random_phase(250);
		wait_idle();
		repeat (10) @(posedge clk);
		$display("sent %0d readings over %0d register settings, checked %0d beats",
			readings_sent, settings_used, beats_checked);
		$display("covered clamp at reference, shift extremes, 64-bit wraps, hold on/off");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d beats still expected", expected_ns.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

[tsc_to_ns_monotonic_clock_top.f]
design/tscns_pkg.sv
design/tscns_cfg.sv
design/tscns_front.sv
design/tscns_queue.sv
design/tscns_back.sv
design/tsc_to_ns_monotonic_clock_top.sv
tb/tsc_to_ns_monotonic_clock_top_test.sv
